/* design/uytb_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// uytb_pkg
// Shared types and constants for the UYVY temporal luma blur: payload
// structs, frame store geometry, index reduction constants.
// ============================================================================
package uytb_pkg;

    localparam int unsigned FRAME_PAIRS = 65536;
    localparam int unsigned ADDR_W      = $clog2(FRAME_PAIRS);
    localparam int unsigned IDX_W       = 16;
    localparam int unsigned LUMA_W      = 8;
    localparam int unsigned STORE_W     = 2 * LUMA_W;

    // floor(x / FRAME_PAIRS) = (x * DIV_M) >> DIV_SH, exact for all IDX_W-bit x
    localparam int unsigned DIV_SH      = IDX_W + ADDR_W;
    localparam int unsigned DIV_M_W     = IDX_W + 1;
    localparam int unsigned DIV_PROD_W  = IDX_W + DIV_M_W;

    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [LUMA_W-1:0]     t_luma;
    typedef logic [STORE_W-1:0]    t_store;
    typedef logic [DIV_M_W-1:0]    t_div_m;
    typedef logic [DIV_PROD_W-1:0] t_div_prod;

    localparam t_div_m DIV_M = t_div_m'(((64'd1 << DIV_SH) + 64'(FRAME_PAIRS) - 64'd1)
                                        / 64'(FRAME_PAIRS));

    localparam t_luma FULL_WEIGHT = 8'd255;
    localparam t_luma LUMA_MIN    = 8'd16;
    localparam t_luma LUMA_MAX    = 8'd235;

    typedef struct packed {
        logic [15:0] pair_index;
        logic [7:0]  u_in;
        logic [7:0]  luma_first_in;
        logic [7:0]  v_in;
        logic [7:0]  luma_second_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] u_out;
        logic [7:0] luma_first_out;
        logic [7:0] v_out;
        logic [7:0] luma_second_out;
    } t_pix_out;

    typedef struct packed {
        logic  busy;
        t_addr addr;
    } t_clr_ctl;

endpackage

/* design/uytb_ram.sv */
`timescale 1ns / 1ps
// ============================================================================
// uytb_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered, enabled read. A read at the address being written returns the
// old contents.
// ============================================================================
module uytb_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/uytb_clear.sv */
`timescale 1ns / 1ps
// ============================================================================
// uytb_clear
// Post-reset sweep of the frame store: walks every entry once, one per
// cycle, and flags busy until the last entry is written.
// ============================================================================
module uytb_clear (
    input  logic               i_clk,
    input  logic               i_rst_n,
    output uytb_pkg::t_clr_ctl o_ctl
);

    localparam uytb_pkg::t_addr LAST_ADDR = uytb_pkg::t_addr'(uytb_pkg::FRAME_PAIRS - 1);

    logic            r_busy;
    uytb_pkg::t_addr r_addr;
    logic            n_busy;
    uytb_pkg::t_addr n_addr;

    always_comb begin
        n_busy = r_busy;
        n_addr = r_addr;
        if (r_busy) begin
            n_addr = r_addr + 1'b1;
            if (r_addr == LAST_ADDR) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else begin
            r_busy <= n_busy;
            r_addr <= n_addr;
        end
    end

    assign o_ctl.busy = r_busy;
    assign o_ctl.addr = r_addr;

endmodule

/* design/uytb_blend.sv */
`timescale 1ns / 1ps
// ============================================================================
// uytb_blend
// Recursive half of the luma blend for both samples of a macropixel: adds
// the weighted stored luma to the weighted fresh term and clamps to video
// range.
// ============================================================================
module uytb_blend (
    input  uytb_pkg::t_luma  i_blur,
    input  uytb_pkg::t_store i_fresh,
    input  uytb_pkg::t_store i_stored,
    output uytb_pkg::t_store o_luma
);

    function automatic uytb_pkg::t_luma blend_one(
        input uytb_pkg::t_luma fresh,
        input uytb_pkg::t_luma stored,
        input uytb_pkg::t_luma blur
    );
        logic [2*uytb_pkg::LUMA_W-1:0] prod;
        logic [uytb_pkg::LUMA_W:0]     sum;
        uytb_pkg::t_luma               res;
        prod = stored * blur;
        sum  = {1'b0, fresh} + {1'b0, prod[2*uytb_pkg::LUMA_W-1 -: uytb_pkg::LUMA_W]};
        if (sum < {1'b0, uytb_pkg::LUMA_MIN}) begin
            res = uytb_pkg::LUMA_MIN;
        end else if (sum > {1'b0, uytb_pkg::LUMA_MAX}) begin
            res = uytb_pkg::LUMA_MAX;
        end else begin
            res = sum[uytb_pkg::LUMA_W-1:0];
        end
        return res;
    endfunction

    assign o_luma[uytb_pkg::LUMA_W-1:0] =
        blend_one(i_fresh[uytb_pkg::LUMA_W-1:0], i_stored[uytb_pkg::LUMA_W-1:0], i_blur);
    assign o_luma[uytb_pkg::STORE_W-1:uytb_pkg::LUMA_W] =
        blend_one(i_fresh[uytb_pkg::STORE_W-1:uytb_pkg::LUMA_W],
                  i_stored[uytb_pkg::STORE_W-1:uytb_pkg::LUMA_W], i_blur);

endmodule

/* design/uyvy_luma_temporal_blur.sv */
`timescale 1ns / 1ps
// ============================================================================
// uyvy_luma_temporal_blur
// Frame-recursive luma blur on UYVY macropixels with an on-chip frame store.
// ============================================================================
// Usage:
//   Input channel i_valid/o_stall/i_pix carries one macropixel and its pair
//   index per transaction; output channel o_valid/i_stall/o_pix returns one
//   blended macropixel per input, in order. Chroma passes through.
//   Config channel i_cfg_valid/o_cfg_ready/i_cfg_data writes blur_amount;
//   write it only while no transaction is in flight.
//   Throughput: one macropixel per cycle while the receiver does not stall
//   and no sweep runs, set by the blend/write-back of the frame store, with
//   a bypass for back-to-back hits on the same entry. The index quotient is
//   taken into stage 1; remainder, store read and fresh weighting run from
//   stage 1, stored weighting, clamp and write-back into the output stage.
//   Reset: blur_amount clears to 0 and the frame store is swept to zero,
//   one entry per cycle over all FRAME_PAIRS (65536) entries; o_stall stays
//   high during the sweep, config writes are still taken.
//   Receiver stall: the output register holds; empty stages upstream keep
//   filling, and o_stall rises only once all three stages are occupied.
// ============================================================================
module uyvy_luma_temporal_blur (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  uytb_pkg::t_pix_in  i_pix,
    output logic               o_valid,
    input  logic               i_stall,
    output uytb_pkg::t_pix_out o_pix,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_data
);

    uytb_pkg::t_clr_ctl  clr;
    logic                accept_in;
    logic                cfg_wr;
    logic                en1;
    logic                en2;
    logic                en3;
    logic                mv12;
    logic                mv23;
    uytb_pkg::t_div_prod div_prod;
    uytb_pkg::t_idx      idx_red;
    uytb_pkg::t_addr     addr1;
    uytb_pkg::t_luma     fresh_w;
    logic [15:0]         fresh_p0;
    logic [15:0]         fresh_p1;
    uytb_pkg::t_store    fresh1;
    uytb_pkg::t_store    ram_rdata;
    uytb_pkg::t_store    stored;
    uytb_pkg::t_store    blend;
    logic                ram_we;
    uytb_pkg::t_addr     ram_waddr;
    uytb_pkg::t_store    ram_wdata;

    uytb_pkg::t_luma     r_blur;
    logic                r_s1_valid;
    uytb_pkg::t_pix_in   r_s1_pix;
    uytb_pkg::t_idx      r_s1_q;
    logic                r_s2_valid;
    uytb_pkg::t_addr     r_s2_addr;
    logic [7:0]          r_s2_u;
    logic [7:0]          r_s2_v;
    uytb_pkg::t_store    r_s2_fresh;
    logic                r_byp;
    uytb_pkg::t_store    r_byp_luma;
    logic                r_s3_valid;
    uytb_pkg::t_pix_out  r_out;

    // ---- handshake and stage advance ----
    assign en3       = !r_s3_valid || !i_stall;
    assign en2       = !r_s2_valid || en3;
    assign en1       = !r_s1_valid || en2;
    assign o_stall   = !en1 || clr.busy;
    assign accept_in = i_valid && !o_stall;
    assign mv12      = en2 && r_s1_valid;
    assign mv23      = en3 && r_s2_valid;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // ---- stage 0 -> 1: quotient of pair index by store depth ----
    assign div_prod = uytb_pkg::t_div_prod'(i_pix.pair_index)
                    * uytb_pkg::t_div_prod'(uytb_pkg::DIV_M);

    // ---- stage 1 -> 2: remainder, fresh luma weighting ----
    assign idx_red  = r_s1_pix.pair_index
                    - uytb_pkg::t_idx'(r_s1_q * uytb_pkg::FRAME_PAIRS);
    assign addr1    = uytb_pkg::t_addr'(idx_red);
    assign fresh_w  = uytb_pkg::FULL_WEIGHT - r_blur;
    assign fresh_p0 = r_s1_pix.luma_first_in * fresh_w;
    assign fresh_p1 = r_s1_pix.luma_second_in * fresh_w;
    assign fresh1   = {fresh_p1[15:8], fresh_p0[15:8]};

    // ---- stage 2 -> 3: recursive blend ----
    assign stored = r_byp ? r_byp_luma : ram_rdata;

    uytb_blend u_blend (
        .i_blur   (r_blur),
        .i_fresh  (r_s2_fresh),
        .i_stored (stored),
        .o_luma   (blend)
    );

    // ---- frame store ----
    uytb_clear u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_ctl   (clr)
    );

    assign ram_we    = clr.busy || mv23;
    assign ram_waddr = clr.busy ? clr.addr : r_s2_addr;
    assign ram_wdata = clr.busy ? '0 : blend;

    uytb_ram #(
        .WIDTH (uytb_pkg::STORE_W),
        .DEPTH (uytb_pkg::FRAME_PAIRS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (mv12),
        .i_raddr (addr1),
        .o_rdata (ram_rdata)
    );

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blur     <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_blur <= i_cfg_data;
            end
            if (en1) begin
                r_s1_valid <= accept_in;
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en3) begin
                r_s3_valid <= r_s2_valid;
            end
            // read-first store: forward the entry written on the read edge
            if (mv12) begin
                r_byp <= mv23 && (r_s2_addr == addr1);
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_s1_pix <= i_pix;
            r_s1_q   <= uytb_pkg::t_idx'(div_prod >> uytb_pkg::DIV_SH);
        end
        if (mv12) begin
            r_s2_addr  <= addr1;
            r_s2_u     <= r_s1_pix.u_in;
            r_s2_v     <= r_s1_pix.v_in;
            r_s2_fresh <= fresh1;
            r_byp_luma <= blend;
        end
        if (mv23) begin
            r_out.u_out           <= r_s2_u;
            r_out.luma_first_out  <= blend[uytb_pkg::LUMA_W-1:0];
            r_out.v_out           <= r_s2_v;
            r_out.luma_second_out <= blend[uytb_pkg::STORE_W-1:uytb_pkg::LUMA_W];
        end
    end

    assign o_valid = r_s3_valid;
    assign o_pix   = r_out;

`ifndef SYNTHESIS
    a_no_item_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr.busy |-> !mv23)
        else $error("item write-back during frame store clear");

    a_out_matches_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mv23 |=> (r_s3_valid &&
                  {r_out.luma_second_out, r_out.luma_first_out} == $past(ram_wdata)))
        else $error("output luma differs from frame store write-back");

    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid |-> (r_out.luma_first_out >= uytb_pkg::LUMA_MIN &&
                        r_out.luma_first_out <= uytb_pkg::LUMA_MAX &&
                        r_out.luma_second_out >= uytb_pkg::LUMA_MIN &&
                        r_out.luma_second_out <= uytb_pkg::LUMA_MAX))
        else $error("output luma outside video range");
`endif

endmodule

/* bench/uyvy_luma_temporal_blur_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// uyvy_luma_temporal_blur_test
// Self-checking bench for the recursive UYVY luma blur. A scoreboard keeps
// its own luma frame store and blur amount, predicts every blended
// macropixel when the input transaction is accepted, and checks results in
// order. A directed pass covers field extremes and all blur extremes. Random
// phases follow that revisit a few frame positions, with sender idling,
// receiver stalls and long output hold-offs.
// ============================================================================
module uyvy_luma_temporal_blur_test;

    class luma_blur_scoreboard;
        bit [uytb_pkg::STORE_W-1:0] frame_luma [uytb_pkg::FRAME_PAIRS];
        bit [uytb_pkg::LUMA_W-1:0]  blur;
        uytb_pkg::t_pix_out         expected_q[$];
        int                         errors;
        int                         checked;
        int                         noted;

        function void set_blur(bit [7:0] amount);
            blur = amount;
        endfunction

        function bit [7:0] blend(bit [7:0] fresh, bit [7:0] stored);
            int unsigned y;
            y = ((32'(fresh) * (32'(uytb_pkg::FULL_WEIGHT) - 32'(blur))) >> 8)
                + ((32'(stored) * 32'(blur)) >> 8);
            if (y < uytb_pkg::LUMA_MIN) y = uytb_pkg::LUMA_MIN;
            if (y > uytb_pkg::LUMA_MAX) y = uytb_pkg::LUMA_MAX;
            return y[7:0];
        endfunction

        function void note_pixel(uytb_pkg::t_pix_in px);
            int unsigned        idx;
            bit [15:0]          entry;
            uytb_pkg::t_pix_out res;
            idx   = px.pair_index % uytb_pkg::FRAME_PAIRS;
            entry = frame_luma[idx];
            res.u_out           = px.u_in;
            res.v_out           = px.v_in;
            res.luma_first_out  = blend(px.luma_first_in, entry[7:0]);
            res.luma_second_out = blend(px.luma_second_in, entry[15:8]);
            frame_luma[idx] = {res.luma_second_out, res.luma_first_out};
            expected_q.push_back(res);
            noted++;
        endfunction

        function void check_pixel(uytb_pkg::t_pix_out px);
            uytb_pkg::t_pix_out want;
            if (expected_q.size() == 0) begin
                $error("result transaction with nothing pending: %h", px);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (px.u_out !== want.u_out) begin
                $error("u_out: expected %0d, got %0d", want.u_out, px.u_out);
                errors++;
            end
            if (px.luma_first_out !== want.luma_first_out) begin
                $error("luma_first_out: expected %0d, got %0d",
                       want.luma_first_out, px.luma_first_out);
                errors++;
            end
            if (px.v_out !== want.v_out) begin
                $error("v_out: expected %0d, got %0d", want.v_out, px.v_out);
                errors++;
            end
            if (px.luma_second_out !== want.luma_second_out) begin
                $error("luma_second_out: expected %0d, got %0d",
                       want.luma_second_out, px.luma_second_out);
                errors++;
            end
        endfunction
    endclass

    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 210;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_valid     = 1'b0;
    logic               o_stall;
    uytb_pkg::t_pix_in  i_pix       = '0;
    logic               o_valid;
    logic               i_stall     = 1'b0;
    uytb_pkg::t_pix_out o_pix;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_data  = 8'd0;

    luma_blur_scoreboard sb;
    int          stall_pct = 0;
    logic        hold_off  = 1'b0;
    logic [15:0] last_index = 16'd0;
    logic [15:0] walk_pos   = 16'd0;
    int          blur_settings = 0;

    const bit [7:0] LUMA_EDGES [6] = '{8'd0, 8'd255, 8'd16, 8'd235, 8'd15, 8'd236};

    uyvy_luma_temporal_blur dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pix       (i_pix),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pix       (o_pix),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_pixel(i_pix);
            if (o_valid && !i_stall) sb.check_pixel(o_pix);
            if (i_cfg_valid && o_cfg_ready) sb.set_blur(i_cfg_data);
        end
    end

    function automatic uytb_pkg::t_pix_in pix(bit [15:0] idx, bit [7:0] u, bit [7:0] y0,
                                              bit [7:0] v, bit [7:0] y1);
        uytb_pkg::t_pix_in p;
        p.pair_index     = idx;
        p.u_in           = u;
        p.luma_first_in  = y0;
        p.v_in           = v;
        p.luma_second_in = y1;
        return p;
    endfunction

    function automatic bit [7:0] random_luma();
        if ($urandom_range(9) < 2) return LUMA_EDGES[$urandom_range(5)];
        return 8'($urandom_range(255));
    endfunction

    // Mostly a small set of positions so the recursion builds up, with
    // back-to-back hits on one entry, a walking frame, and the odd far index.
    function automatic uytb_pkg::t_pix_in random_pixel();
        int          r;
        logic [15:0] idx;
        r = $urandom_range(99);
        if (r < 45) begin
            idx = 16'($urandom_range(15));
        end else if (r < 60) begin
            idx = last_index;
        end else if (r < 72) begin
            idx = walk_pos;
            walk_pos = (walk_pos + 16'd1) % 16'd24;
        end else if (r < 80) begin
            case ($urandom_range(3))
                0: idx = 16'd0;
                1: idx = 16'd1;
                2: idx = 16'hFFFE;
                default: idx = 16'hFFFF;
            endcase
        end else begin
            idx = 16'($urandom_range(65535));
        end
        last_index = idx;
        return pix(idx, 8'($urandom_range(255)), random_luma(),
                   8'($urandom_range(255)), random_luma());
    endfunction

    task automatic send_pixel(uytb_pkg::t_pix_in p, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pix   <= p;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic write_blur(bit [7:0] amount);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= amount;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        blur_settings++;
    endtask

    // one edge first so the last accepted transaction is already noted
    task automatic wait_idle();
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic hold_off_stretch(int cycles);
        repeat (20) @(negedge i_clk);
        hold_off = 1'b1;
        repeat (cycles) @(negedge i_clk);
        hold_off = 1'b0;
    endtask

    initial begin
        int idle_plan  [PHASES];
        int stall_plan [PHASES];
        int blur_plan  [PHASES];

        sb = new();
        idle_plan  = '{0, 46, 0, 18, 0, 46, 0, 18};
        stall_plan = '{0, 0, 46, 18, 0, 0, 46, 18};
        blur_plan = '{0, 255, 1, 254, 0, 128, 0, 0};
        blur_plan[4] = $urandom_range(255);
        blur_plan[6] = $urandom_range(255);
        blur_plan[7] = $urandom_range(255);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // first frame: store still zero, written while the clear runs
        write_blur(8'd128);
        send_pixel(pix(16'd0, 8'd0, 8'd0, 8'd0, 8'd0), 0);
        send_pixel(pix(16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255), 0);
        send_pixel(pix(16'hAAAA, 8'h55, 8'hAA, 8'h55, 8'hAA), 0);
        send_pixel(pix(16'h5555, 8'hAA, 8'h55, 8'hAA, 8'h55), 0);
        send_pixel(pix(16'd1, 8'h0F, 8'd15, 8'hF0, 8'd236), 0);
        send_pixel(pix(16'd2, 8'd1, 8'd16, 8'd254, 8'd235), 0);
        send_pixel(pix(16'd0, 8'd7, 8'd200, 8'd9, 8'd100), 0);
        i_valid <= 1'b0;
        wait_idle();

        write_blur(8'd0);
        send_pixel(pix(16'd3, 8'd12, 8'd0, 8'd34, 8'd255), 0);
        send_pixel(pix(16'd4, 8'd56, 8'd15, 8'd78, 8'd236), 0);
        send_pixel(pix(16'hFFFF, 8'd0, 8'd128, 8'd0, 8'd17), 0);
        i_valid <= 1'b0;
        wait_idle();

        // heavy blur, back-to-back hits on one entry
        write_blur(8'd255);
        send_pixel(pix(16'd0, 8'd90, 8'd255, 8'd91, 8'd255), 0);
        send_pixel(pix(16'd0, 8'd92, 8'd255, 8'd93, 8'd255), 0);
        send_pixel(pix(16'd0, 8'd94, 8'd255, 8'd95, 8'd255), 0);
        send_pixel(pix(16'hFFFF, 8'd3, 8'd0, 8'd4, 8'd0), 0);
        send_pixel(pix(16'hFFFF, 8'd5, 8'd0, 8'd6, 8'd0), 0);
        send_pixel(pix(16'hAAAA, 8'd7, 8'd235, 8'd8, 8'd16), 0);
        i_valid <= 1'b0;
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            write_blur(8'(blur_plan[ph]));
            stall_pct = stall_plan[ph];
            if (ph == 0 || ph == 4) begin
                fork
                    hold_off_stretch(90);
                join_none
            end
            for (int n = 0; n < PHASE_LEN; n++) send_pixel(random_pixel(), idle_plan[ph]);
            i_valid <= 1'b0;
            wait_idle();
        end

        stall_pct = 0;
        repeat (10) @(posedge i_clk);
        $display("Run: %0d macropixels, %0d results checked over %0d blur settings,",
                 sb.noted, sb.checked, blur_settings);
        $display("with sender gaps, receiver stalls and long output hold-offs.");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: %0d results still pending", sb.expected_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* uyvy_luma_temporal_blur.f */
design/uytb_pkg.sv
design/uytb_ram.sv
design/uytb_clear.sv
design/uytb_blend.sv
design/uyvy_luma_temporal_blur.sv
bench/uyvy_luma_temporal_blur_test.sv
